FILE: sv/stop_wait_link_sequencer_assert.svh
// Assertion macros for the stop-and-wait link sequencer checker.
// Each macro expects clk and arst_n in the scope that uses it.
`ifndef STOP_WAIT_LINK_SEQUENCER_ASSERT_SVH
`define STOP_WAIT_LINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SWL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SWL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/swl_pkg.sv
// Shared constants and codes of the stop-and-wait link sequencer.
// No dependencies; used by the channel interfaces, the top level and the checker.
package swl_pkg;

	// Queue and field sizes
	localparam int Q_DEPTH    = 16;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int Q_CW       = $clog2(Q_DEPTH + 1);
	localparam int SEQ_W      = 32;
	localparam int HANDLE_W   = 16;
	localparam int TMR_W      = 16;
	localparam int RETRY_W    = 4;
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Commands
	localparam logic [CMD_W-1:0] CMD_RECV = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PULL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

	// Queue entry kinds
	localparam logic [KIND_W-1:0] KIND_USER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PROBE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RESP_TO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONN_TO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 2'd2;

	// Register reset values
	localparam logic [TMR_W-1:0]   RESP_TO_RST   = 16'd1500;
	localparam logic [TMR_W-1:0]   CONN_TO_RST   = 16'd7000;
	localparam logic [RETRY_W-1:0] RETRY_LIM_RST = 4'd3;

endpackage

FILE: sv/swl_if.sv
// Valid/ready channels of the stop-and-wait link sequencer: command words in,
// result words out. Depends on swl_pkg.
interface swl_req_if;
	import swl_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SEQ_W-1:0]    rx_seq;
	logic                rx_is_ack;
	logic [HANDLE_W-1:0] msg_handle;
	logic                msg_extra;

	modport source (output valid, cmd, rx_seq, rx_is_ack, msg_handle, msg_extra,
		input ready);
	modport sink (input valid, cmd, rx_seq, rx_is_ack, msg_handle, msg_extra,
		output ready);
endinterface

interface swl_rsp_if;
	import swl_pkg::*;

	logic                valid;
	logic                ready;
	logic                further_needed;
	logic                send_ready;
	logic                online;
	logic                online_changed;
	logic                tx_valid;
	logic [KIND_W-1:0]   tx_kind;
	logic [HANDLE_W-1:0] tx_handle;
	logic [SEQ_W-1:0]    tx_seq;
	logic [SEQ_W-1:0]    tx_ack_seq;
	logic                queue_overflow;

	modport source (output valid, further_needed, send_ready, online, online_changed,
		tx_valid, tx_kind, tx_handle, tx_seq, tx_ack_seq, queue_overflow,
		input ready);
	modport sink (input valid, further_needed, send_ready, online, online_changed,
		tx_valid, tx_kind, tx_handle, tx_seq, tx_ack_seq, queue_overflow,
		output ready);
endinterface

FILE: sv/stop_wait_link_sequencer.sv
// Stop-and-wait link endpoint; depends on swl_pkg and swl_if.sv.
// Results are registered in the output register, or the skid register on a stall.
// Throughput: one word per cycle while the skid register is empty; a tick queueing
// a retransmission and a probe holds off the next word (one send queue write port).
// Reset: control state, timers and registers return to defaults at once; the queue
// memory is not cleared (no clearing pass), an empty queue never reads it.
module stop_wait_link_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swl_pkg::CFG_DATA_W-1:0]   cfg_data,
	swl_req_if.sink                          req,
	swl_rsp_if.source                        rsp
);
	import swl_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic                extra;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Queue pointers, head copy and up to two writes made by one word
	typedef struct packed {
		logic [Q_AW-1:0] head;
		logic [Q_CW-1:0] count;
		entry_t          hent;
		logic            ovf;
		logic            w0_v;
		logic [Q_AW-1:0] w0_a;
		entry_t          w0_d;
		logic            w1_v;
		logic [Q_AW-1:0] w1_a;
		entry_t          w1_d;
	} qs_t;

	typedef struct packed {
		logic                further_needed;
		logic                send_ready;
		logic                online;
		logic                online_changed;
		logic                tx_valid;
		logic [KIND_W-1:0]   tx_kind;
		logic [HANDLE_W-1:0] tx_handle;
		logic [SEQ_W-1:0]    tx_seq;
		logic [SEQ_W-1:0]    tx_ack_seq;
		logic                queue_overflow;
	} res_t;

	function automatic logic [Q_AW-1:0] q_inc(input logic [Q_AW-1:0] h);
		return (h == Q_AW'(Q_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	function automatic logic [Q_AW-1:0] q_dec(input logic [Q_AW-1:0] h);
		return (h == '0) ? Q_AW'(Q_DEPTH - 1) : h - 1'b1;
	endfunction

	function automatic logic [Q_AW-1:0] q_add(input logic [Q_AW-1:0] h,
			input logic [Q_CW-1:0] n);
		logic [Q_AW:0] s;
		s = (Q_AW + 1)'(h) + (Q_AW + 1)'(n);
		if (s >= (Q_AW + 1)'(Q_DEPTH))
			s = s - (Q_AW + 1)'(Q_DEPTH);
		return s[Q_AW-1:0];
	endfunction

	// Insert one entry at the front or the back, or flag a drop when full
	function automatic qs_t q_push(input qs_t s, input logic [KIND_W-1:0] kind,
			input logic [HANDLE_W-1:0] handle, input logic extra);
		qs_t             r;
		entry_t          e;
		logic [Q_AW-1:0] a;
		r        = s;
		e.kind   = kind;
		e.extra  = extra;
		e.handle = handle;
		a        = '0;
		if (s.count >= Q_CW'(Q_DEPTH)) begin
			r.ovf = 1'b1;
		end else begin
			if (extra) begin
				r.head = q_dec(s.head);
				r.hent = e;
				a      = r.head;
			end else begin
				a = q_add(s.head, s.count);
				if (s.count == '0)
					r.hent = e;
			end
			if (!s.w0_v) begin
				r.w0_v = 1'b1;
				r.w0_a = a;
				r.w0_d = e;
			end else begin
				r.w1_v = 1'b1;
				r.w1_a = a;
				r.w1_d = e;
			end
			r.count = s.count + 1'b1;
		end
		return r;
	endfunction

	// Registers
	logic [TMR_W-1:0]    resp_to_q, conn_to_q;
	logic [RETRY_W-1:0]  retry_lim_q;
	logic [Q_AW-1:0]     head_q;
	logic [Q_CW-1:0]     count_q;
	entry_t              hent_q;
	logic [KIND_W-1:0]   last_kind_q;
	logic [HANDLE_W-1:0] last_handle_q;
	logic [SEQ_W-1:0]    rx_base_q, tx_ctr_q;
	logic                acked_q, online_q;
	logic [TMR_W-1:0]    resp_cnt_q, conn_cnt_q;
	logic                resp_run_q, conn_run_q;
	logic [RETRY_W-1:0]  retries_q;
	logic                pend_q;
	logic [Q_AW-1:0]     pend_a_q;
	entry_t              pend_d_q;
	entry_t              rd_q, fwd_d_q;
	logic                fwd_hit_q;
	res_t                out_q, skid_q;
	logic                out_v_q, skid_v_q;

	// Next-state values
	qs_t                 q;
	logic [KIND_W-1:0]   last_kind_n;
	logic [HANDLE_W-1:0] last_handle_n;
	logic [SEQ_W-1:0]    rx_base_n, tx_ctr_n;
	logic                acked_n, online_n;
	logic [TMR_W-1:0]    resp_cnt_n, conn_cnt_n;
	logic                resp_run_n, conn_run_n;
	logic [RETRY_W-1:0]  retries_n;
	res_t                res;

	logic                acc, take;
	entry_t              next_ent, pull_ent;
	logic [SEQ_W-1:0]    base_inc;
	logic                mem_we;
	logic [Q_AW-1:0]     mem_wa, mem_ra;
	entry_t              mem_wd;
	entry_t              mem [Q_DEPTH];

	assign acc      = req.valid && req.ready;
	assign take     = out_v_q && rsp.ready;
	assign req.ready = !skid_v_q && !pend_q;
	assign base_inc = rx_base_q + 1'b1;
	// Entry behind the head, with last cycle's write folded in
	assign next_ent = fwd_hit_q ? fwd_d_q : rd_q;

	// Evaluate one command word against the current state
	always_comb begin
		q             = '0;
		q.head        = head_q;
		q.count       = count_q;
		q.hent        = hent_q;
		last_kind_n   = last_kind_q;
		last_handle_n = last_handle_q;
		rx_base_n     = rx_base_q;
		tx_ctr_n      = tx_ctr_q;
		acked_n       = acked_q;
		online_n      = online_q;
		resp_cnt_n    = resp_cnt_q;
		conn_cnt_n    = conn_cnt_q;
		resp_run_n    = resp_run_q;
		conn_run_n    = conn_run_q;
		retries_n     = retries_q;
		pull_ent      = hent_q;
		res           = '0;
		if (acc) begin
			case (req.cmd)
				CMD_RECV: begin
					if (req.rx_seq == rx_base_q && !req.rx_is_ack) begin
						q = q_push(q, KIND_ACK, '0, 1'b1);
					end else if (req.rx_seq == base_inc) begin
						rx_base_n = req.rx_seq;
						if (req.rx_is_ack) begin
							acked_n = 1'b1;
						end else begin
							q = q_push(q, KIND_ACK, '0, 1'b0);
							res.further_needed = 1'b1;
						end
					end
					conn_run_n = 1'b1;
					conn_cnt_n = '0;
					if (!online_q) begin
						online_n = 1'b1;
						res.online_changed = 1'b1;
					end
				end
				CMD_ENQ: begin
					q = q_push(q, KIND_USER, req.msg_handle, req.msg_extra);
				end
				CMD_PULL: begin
					if (count_q != '0) begin
						pull_ent = hent_q;
						q.head   = q_inc(head_q);
						q.count  = count_q - 1'b1;
						q.hent   = next_ent;
						if (pull_ent.kind != KIND_ACK) begin
							acked_n       = 1'b0;
							last_kind_n   = pull_ent.kind;
							last_handle_n = pull_ent.handle;
							resp_run_n    = 1'b1;
							resp_cnt_n    = '0;
						end
						if (!pull_ent.extra)
							tx_ctr_n = tx_ctr_q + 1'b1;
						res.tx_valid   = 1'b1;
						res.tx_kind    = pull_ent.kind;
						res.tx_handle  = pull_ent.handle;
						res.tx_seq     = tx_ctr_n;
						res.tx_ack_seq = base_inc;
					end
				end
				CMD_TICK: begin
					// Response timer acts before the connection timer
					if (resp_run_q) begin
						resp_cnt_n = resp_cnt_q + 1'b1;
						if (resp_cnt_n >= resp_to_q) begin
							resp_run_n = 1'b0;
							if (acked_q) begin
								retries_n = '0;
							end else begin
								q = q_push(q, last_kind_q, last_handle_q, 1'b1);
								resp_run_n = 1'b1;
								resp_cnt_n = '0;
								if (last_kind_q == KIND_PROBE) begin
									retries_n = retries_q + 1'b1;
									if (retries_n == retry_lim_q) begin
										resp_run_n = 1'b0;
										resp_cnt_n = resp_cnt_q + 1'b1;
										if (online_q) begin
											online_n = 1'b0;
											res.online_changed = 1'b1;
										end
									end
								end
							end
						end
					end
					if (conn_run_q) begin
						conn_cnt_n = conn_cnt_q + 1'b1;
						if (conn_cnt_n >= conn_to_q) begin
							conn_run_n = 1'b0;
							q = q_push(q, KIND_PROBE, '0, 1'b0);
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.online         = online_n;
		res.queue_overflow = q.ovf;
		res.send_ready     = (q.count != '0) && (acked_n || (q.hent.extra &&
			q.hent.kind == last_kind_n && q.hent.handle == last_handle_n));
	end

	// Memory ports: a deferred second write takes the port first
	assign mem_we = pend_q || (acc && q.w0_v);
	assign mem_wa = pend_q ? pend_a_q : q.w0_a;
	assign mem_wd = pend_q ? pend_d_q : q.w0_d;
	assign mem_ra = q_inc(q.head);

	// Send queue memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q    <= mem[mem_ra];
		fwd_d_q <= mem_wd;
	end

	// Hold the second write of a double push
	always_ff @(posedge clk) begin
		pend_a_q <= q.w1_a;
		pend_d_q <= q.w1_d;
	end

	// Advance state and load registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_to_q     <= RESP_TO_RST;
			conn_to_q     <= CONN_TO_RST;
			retry_lim_q   <= RETRY_LIM_RST;
			head_q        <= '0;
			count_q       <= '0;
			last_kind_q   <= KIND_USER;
			last_handle_q <= '0;
			rx_base_q     <= '0;
			tx_ctr_q      <= '0;
			acked_q       <= 1'b1;
			online_q      <= 1'b0;
			resp_cnt_q    <= '0;
			conn_cnt_q    <= '0;
			resp_run_q    <= 1'b0;
			conn_run_q    <= 1'b0;
			retries_q     <= '0;
			pend_q        <= 1'b0;
			fwd_hit_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RESP_TO:   resp_to_q   <= cfg_data[TMR_W-1:0];
					CFG_CONN_TO:   conn_to_q   <= cfg_data[TMR_W-1:0];
					CFG_RETRY_LIM: retry_lim_q <= cfg_data[RETRY_W-1:0];
					default: begin
					end
				endcase
			end
			head_q        <= q.head;
			count_q       <= q.count;
			last_kind_q   <= last_kind_n;
			last_handle_q <= last_handle_n;
			rx_base_q     <= rx_base_n;
			tx_ctr_q      <= tx_ctr_n;
			acked_q       <= acked_n;
			online_q      <= online_n;
			resp_cnt_q    <= resp_cnt_n;
			conn_cnt_q    <= conn_cnt_n;
			resp_run_q    <= resp_run_n;
			conn_run_q    <= conn_run_n;
			retries_q     <= retries_n;
			pend_q        <= acc && q.w1_v;
			fwd_hit_q     <= mem_we && (mem_wa == mem_ra);
		end
	end

	// Head copy follows the queue front
	always_ff @(posedge clk) begin
		hent_q <= q.hent;
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take)
				skid_v_q <= 1'b0;
		end else if (acc) begin
			if (out_v_q && !take)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take)
				out_q <= skid_q;
		end else if (acc) begin
			if (out_v_q && !take)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	// Drive the result channel
	assign rsp.valid          = out_v_q;
	assign rsp.further_needed = out_q.further_needed;
	assign rsp.send_ready     = out_q.send_ready;
	assign rsp.online         = out_q.online;
	assign rsp.online_changed = out_q.online_changed;
	assign rsp.tx_valid       = out_q.tx_valid;
	assign rsp.tx_kind        = out_q.tx_kind;
	assign rsp.tx_handle      = out_q.tx_handle;
	assign rsp.tx_seq         = out_q.tx_seq;
	assign rsp.tx_ack_seq     = out_q.tx_ack_seq;
	assign rsp.queue_overflow = out_q.queue_overflow;

endmodule

FILE: sv/swl_chk.sv
// Port-level checker for the stop-and-wait link sequencer, with its bind.
// Depends on swl_pkg and stop_wait_link_sequencer_assert.svh.
`include "stop_wait_link_sequencer_assert.svh"

module swl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           tx_valid,
	input logic [swl_pkg::KIND_W-1:0]     tx_kind,
	input logic [swl_pkg::HANDLE_W-1:0]   tx_handle,
	input logic [swl_pkg::SEQ_W-1:0]      tx_seq,
	input logic [swl_pkg::SEQ_W-1:0]      tx_ack_seq
);
	import swl_pkg::*;

	// Input is only held off while a result word is waiting
	`SWL_ASSERT_NOW(a_stall_has_backlog, !req_ready, rsp_valid, "input stalled with no result pending")

	// A word taken with nothing pending shows its result next cycle
	`SWL_ASSERT_NEXT(a_result_follows, req_valid && req_ready && !rsp_valid, rsp_valid, "result word missing")

	// A result word without a transmission carries zero transmit fields
	`SWL_ASSERT_NOW(a_idle_tx_zero, rsp_valid && !tx_valid, tx_kind == KIND_USER && tx_handle == '0 && tx_seq == '0 && tx_ack_seq == '0, "transmit fields not zero")

	// A stalled result word stays valid with tx_seq and tx_valid unchanged
	`SWL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(tx_seq) && $stable(tx_valid), "result word changed under stall")

endmodule

bind stop_wait_link_sequencer swl_chk u_swl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.tx_valid   (rsp.tx_valid),
	.tx_kind    (rsp.tx_kind),
	.tx_handle  (rsp.tx_handle),
	.tx_seq     (rsp.tx_seq),
	.tx_ack_seq (rsp.tx_ack_seq)
);

FILE: bench/stop_wait_link_sequencer_test.sv
// Self-checking bench for stop_wait_link_sequencer: drives command words with random gaps
// and stalls, predicts each result word, and compares in order. Depends on swl_pkg,
// swl_if.sv and the top level.
module stop_wait_link_sequencer_test;
	import swl_pkg::*;

	typedef struct packed {
		bit [KIND_W-1:0]   kind;
		bit [HANDLE_W-1:0] handle;
		bit                extra;
	} slot_t;

	typedef struct packed {
		bit [CMD_W-1:0]    cmd;
		bit [SEQ_W-1:0]    rx_seq;
		bit                rx_is_ack;
		bit [HANDLE_W-1:0] handle;
		bit                extra;
	} cmd_word_t;

	typedef struct packed {
		logic                further;
		logic                send_ready;
		logic                online;
		logic                changed;
		logic                tx_valid;
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
		logic [SEQ_W-1:0]    seq;
		logic [SEQ_W-1:0]    ack_seq;
		logic                overflow;
	} result_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	swl_req_if req_ch ();
	swl_rsp_if rsp_ch ();

	stop_wait_link_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// Link state as the block should hold it
	slot_t             sq_mem [Q_DEPTH];
	bit [Q_AW-1:0]     sq_head = '0;
	int                sq_count = 0;
	bit [KIND_W-1:0]   last_kind = KIND_USER;
	bit [HANDLE_W-1:0] last_handle = '0;
	bit [SEQ_W-1:0]    rx_base = '0;
	bit [SEQ_W-1:0]    tx_ctr = '0;
	bit                acked_m = 1'b1;
	bit                online_m = 1'b0;
	bit [TMR_W-1:0]    resp_cnt = '0;
	bit                resp_run = 1'b0;
	bit [TMR_W-1:0]    conn_cnt = '0;
	bit                conn_run = 1'b0;
	bit [RETRY_W-1:0]  retries = '0;
	bit [TMR_W-1:0]    resp_to = RESP_TO_RST;
	bit [TMR_W-1:0]    conn_to = CONN_TO_RST;
	bit [RETRY_W-1:0]  retry_lim = RETRY_LIM_RST;
	bit                step_overflow;
	bit                step_changed;

	// Bench bookkeeping
	cmd_word_t    pending_words [$];
	result_word_t due_results [$];
	bit [SEQ_W-1:0] peer_base = '0;
	int  fault_count = 0;
	int  results_seen = 0;
	int  send_gap_max = 0;
	int  recv_gap_max = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  offering = 1'b0;
	bit  word_taken = 1'b0;
	bit  result_taken = 1'b0;
	bit  want_long_hold = 1'b0;
	bit  long_hold_done = 1'b0;
	cmd_word_t    cur_word;
	cmd_word_t    seen_word;
	result_word_t got_res;
	result_word_t want_res;

	function automatic void push_slot(bit [KIND_W-1:0] kind, bit [HANDLE_W-1:0] handle,
			bit extra);
		bit [Q_AW-1:0] idx;
		if (sq_count >= Q_DEPTH) begin
			step_overflow = 1'b1;
			return;
		end
		if (extra) begin
			sq_head = sq_head - 1'b1;
			idx = sq_head;
		end else begin
			idx = sq_head + sq_count[Q_AW-1:0];
		end
		sq_mem[idx] = '{kind: kind, handle: handle, extra: extra};
		sq_count++;
	endfunction

	function automatic void mark_online(bit v);
		if (v != online_m) begin
			online_m = v;
			step_changed = 1'b1;
		end
	endfunction

	// Advance the link state by one command word and return its result word
	function automatic result_word_t link_result(cmd_word_t w);
		result_word_t r;
		slot_t        e;
		bit           restart;
		r = '0;
		step_overflow = 1'b0;
		step_changed = 1'b0;
		case (w.cmd)
			CMD_RECV: begin
				if (w.rx_seq == rx_base && !w.rx_is_ack) begin
					push_slot(KIND_ACK, '0, 1'b1);
				end else if (w.rx_seq == rx_base + 1'b1) begin
					rx_base = w.rx_seq;
					if (w.rx_is_ack) begin
						acked_m = 1'b1;
					end else begin
						push_slot(KIND_ACK, '0, 1'b0);
						r.further = 1'b1;
					end
				end
				conn_run = 1'b1;
				conn_cnt = '0;
				mark_online(1'b1);
			end
			CMD_ENQ: push_slot(KIND_USER, w.handle, w.extra);
			CMD_PULL: begin
				if (sq_count != 0) begin
					e = sq_mem[sq_head];
					sq_head = sq_head + 1'b1;
					sq_count--;
					if (e.kind != KIND_ACK) begin
						acked_m = 1'b0;
						last_kind = e.kind;
						last_handle = e.handle;
						resp_run = 1'b1;
						resp_cnt = '0;
					end
					if (!e.extra) tx_ctr = tx_ctr + 1'b1;
					r.tx_valid = 1'b1;
					r.kind = e.kind;
					r.handle = e.handle;
					r.seq = tx_ctr;
					r.ack_seq = rx_base + 1'b1;
				end
			end
			CMD_TICK: begin
				// Response timer acts before the connection timer
				if (resp_run) begin
					resp_cnt = resp_cnt + 1'b1;
					if (resp_cnt >= resp_to) begin
						resp_run = 1'b0;
						if (acked_m) begin
							retries = '0;
						end else begin
							push_slot(last_kind, last_handle, 1'b1);
							restart = 1'b1;
							if (last_kind == KIND_PROBE) begin
								retries = retries + 1'b1;
								if (retries == retry_lim) begin
									mark_online(1'b0);
									restart = 1'b0;
								end
							end
							if (restart) begin
								resp_run = 1'b1;
								resp_cnt = '0;
							end
						end
					end
				end
				if (conn_run) begin
					conn_cnt = conn_cnt + 1'b1;
					if (conn_cnt >= conn_to) begin
						conn_run = 1'b0;
						push_slot(KIND_PROBE, '0, 1'b0);
					end
				end
			end
			default: ;
		endcase
		r.send_ready = (sq_count != 0) && (acked_m || (sq_mem[sq_head].extra &&
			sq_mem[sq_head].kind == last_kind && sq_mem[sq_head].handle == last_handle));
		r.online = online_m;
		r.changed = step_changed;
		r.overflow = step_overflow;
		return r;
	endfunction

	function automatic string show(result_word_t r);
		return $sformatf("fn=%b sr=%b on=%b chg=%b tv=%b kind=%0d h=%h seq=%h ack=%h ovf=%b",
			r.further, r.send_ready, r.online, r.changed, r.tx_valid, r.kind, r.handle,
			r.seq, r.ack_seq, r.overflow);
	endfunction

	task automatic note_fault(string msg);
		fault_count++;
		if (fault_count <= 10) $display("%0t mismatch: %s", $time, msg);
	endtask

	// Sample config writes, accepted command words and accepted result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RESP_TO:   resp_to = cfg_data;
					CFG_CONN_TO:   conn_to = cfg_data;
					CFG_RETRY_LIM: retry_lim = cfg_data[RETRY_W-1:0];
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_word = '{cmd: req_ch.cmd, rx_seq: req_ch.rx_seq, rx_is_ack: req_ch.rx_is_ack,
					handle: req_ch.msg_handle, extra: req_ch.msg_extra};
				due_results = {due_results, link_result(seen_word)};
				word_taken = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				result_taken = 1'b1;
				results_seen++;
				got_res = '{further: rsp_ch.further_needed, send_ready: rsp_ch.send_ready,
					online: rsp_ch.online, changed: rsp_ch.online_changed,
					tx_valid: rsp_ch.tx_valid, kind: rsp_ch.tx_kind, handle: rsp_ch.tx_handle,
					seq: rsp_ch.tx_seq, ack_seq: rsp_ch.tx_ack_seq,
					overflow: rsp_ch.queue_overflow};
				if (due_results.size() == 0) begin
					note_fault($sformatf("unexpected result word %s", show(got_res)));
				end else begin
					want_res = due_results[0];
					due_results.delete(0);
					if (got_res.further !== want_res.further ||
							got_res.send_ready !== want_res.send_ready ||
							got_res.online !== want_res.online ||
							got_res.changed !== want_res.changed ||
							got_res.tx_valid !== want_res.tx_valid ||
							got_res.kind !== want_res.kind ||
							got_res.handle !== want_res.handle ||
							got_res.seq !== want_res.seq ||
							got_res.ack_seq !== want_res.ack_seq ||
							got_res.overflow !== want_res.overflow)
						note_fault($sformatf("result %0d want %s got %s", results_seen,
							show(want_res), show(got_res)));
				end
			end
		end
	end

	// Present command words, with a drawn gap before each
	always @(negedge clk) begin
		if (word_taken) begin
			word_taken = 1'b0;
			offering = 1'b0;
			gap_left = $urandom_range(0, send_gap_max);
		end
		if (!offering && arst_n) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_words.size() != 0) begin
				cur_word = pending_words[0];
				pending_words.delete(0);
				offering = 1'b1;
				req_ch.cmd <= cur_word.cmd;
				req_ch.rx_seq <= cur_word.rx_seq;
				req_ch.rx_is_ack <= cur_word.rx_is_ack;
				req_ch.msg_handle <= cur_word.handle;
				req_ch.msg_extra <= cur_word.extra;
			end
		end
		req_ch.valid <= offering;
	end

	// Stall result words at random; hold off once for a long stretch
	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 1'b0;
			stall_left = $urandom_range(0, recv_gap_max);
		end
		if (want_long_hold && !long_hold_done) begin
			hold_left = 300;
			long_hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic add_word(bit [CMD_W-1:0] cmd, bit [SEQ_W-1:0] seq, bit ack,
			bit [HANDLE_W-1:0] handle, bit extra);
		cmd_word_t w;
		// Track the partner's view of the receive sequence
		if (cmd == CMD_RECV && seq == peer_base + 1'b1) peer_base = seq;
		w = '{cmd: cmd, rx_seq: seq, rx_is_ack: ack, handle: handle, extra: extra};
		pending_words = {pending_words, w};
	endtask

	task automatic queue_random(int n, int w_recv, int w_enq, int w_pull, int w_tick);
		int pick;
		int sub;
		bit [HANDLE_W-1:0] handle;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, w_recv + w_enq + w_pull + w_tick - 1);
			sub = $urandom_range(0, 99);
			if (pick < w_recv) begin
				// Mostly in-order traffic, some duplicates and stray numbers
				if (sub < 40)
					add_word(CMD_RECV, peer_base + 1'b1, 1'b0, HANDLE_W'($urandom),
						1'($urandom));
				else if (sub < 60)
					add_word(CMD_RECV, peer_base + 1'b1, 1'b1, HANDLE_W'($urandom),
						1'($urandom));
				else if (sub < 75)
					add_word(CMD_RECV, peer_base, 1'b0, HANDLE_W'($urandom), 1'($urandom));
				else if (sub < 85)
					add_word(CMD_RECV, peer_base, 1'b1, HANDLE_W'($urandom), 1'($urandom));
				else
					add_word(CMD_RECV, $urandom, 1'($urandom_range(0, 1)),
						HANDLE_W'($urandom), 1'($urandom));
			end else if (pick < w_recv + w_enq) begin
				if (sub < 10) handle = '0;
				else if (sub < 20) handle = '1;
				else handle = HANDLE_W'($urandom);
				add_word(CMD_ENQ, $urandom, 1'($urandom_range(0, 1)), handle,
					$urandom_range(0, 3) == 0);
			end else if (pick < w_recv + w_enq + w_pull) begin
				add_word(CMD_PULL, $urandom, 1'($urandom_range(0, 1)), HANDLE_W'($urandom),
					1'($urandom));
			end else begin
				add_word(CMD_TICK, $urandom, 1'($urandom_range(0, 1)), HANDLE_W'($urandom),
					1'($urandom));
			end
		end
	endtask

	// Wait until every word is sent and every result is back, then let the block settle
	task automatic settle();
		int waited;
		waited = 0;
		while ((pending_words.size() != 0 || offering || due_results.size() != 0) &&
				waited < 60000) begin
			@(negedge clk);
			waited++;
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_timers(int resp, int conn, int lim);
		write_reg(CFG_RESP_TO, CFG_DATA_W'(resp));
		write_reg(CFG_CONN_TO, CFG_DATA_W'(conn));
		write_reg(CFG_RETRY_LIM, CFG_DATA_W'(lim));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_PULL;
		req_ch.rx_seq = '0;
		req_ch.rx_is_ack = 1'b0;
		req_ch.msg_handle = '0;
		req_ch.msg_extra = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: shortest timers so both expire on one tick and one retry goes offline
		set_timers(1, 1, 1);
		add_word(CMD_PULL, '0, 1'b0, '0, 1'b0);         // pull on empty queue
		add_word(CMD_RECV, '0, 1'b0, '0, 1'b0);         // duplicate: ack at front
		add_word(CMD_RECV, 32'd1, 1'b0, '0, 1'b0);      // in order: new data
		add_word(CMD_RECV, '1, 1'b1, '1, 1'b1);         // out of order: ignored
		add_word(CMD_ENQ, '0, 1'b0, '1, 1'b0);
		add_word(CMD_ENQ, '0, 1'b0, '0, 1'b1);          // extra entry at front
		add_word(CMD_PULL, '0, 1'b0, '0, 1'b0);
		add_word(CMD_PULL, '0, 1'b0, '0, 1'b0);         // pull while not ready
		add_word(CMD_TICK, '0, 1'b0, '0, 1'b0);         // retransmit plus probe
		repeat (4) add_word(CMD_PULL, '0, 1'b0, '0, 1'b0);
		add_word(CMD_TICK, '0, 1'b0, '0, 1'b0);         // probe retry goes offline
		add_word(CMD_RECV, 32'd2, 1'b1, '0, 1'b0);
		add_word(CMD_PULL, '0, 1'b0, '0, 1'b0);
		add_word(CMD_RECV, 32'd3, 1'b1, '0, 1'b0);
		add_word(CMD_TICK, '0, 1'b0, '0, 1'b0);         // expiry while acked clears retries
		settle();

		// Balanced traffic with gaps on both sides
		set_timers(3, 5, 2);
		send_gap_max = 9;
		recv_gap_max = 9;
		queue_random(400, 30, 25, 25, 20);
		settle();

		// Quiet partner: probes pile up until the link drops
		set_timers(2, 4, 15);
		send_gap_max = 0;
		recv_gap_max = 9;
		queue_random(300, 5, 10, 40, 45);
		settle();

		// Enqueue burst against a held-off receiver to fill the queue
		set_timers(65535, 65535, 1);
		send_gap_max = 0;
		recv_gap_max = 0;
		want_long_hold = 1'b1;
		queue_random(300, 25, 60, 10, 5);
		settle();

		set_timers(1, 1, 1);
		send_gap_max = 9;
		recv_gap_max = 0;
		queue_random(300, 20, 20, 30, 30);
		settle();

		for (int k = 0; k < 3; k++) begin
			set_timers($urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(1, 4));
			send_gap_max = $urandom_range(0, 1) * 9;
			recv_gap_max = $urandom_range(0, 1) * 9;
			queue_random(200, 25, 25, 30, 20);
			settle();
		end

		// Back to the reset values
		set_timers(int'(RESP_TO_RST), int'(CONN_TO_RST), int'(RETRY_LIM_RST));
		send_gap_max = 9;
		recv_gap_max = 9;
		queue_random(150, 30, 25, 25, 20);
		settle();

		if (due_results.size() != 0)
			note_fault($sformatf("%0d result words never arrived", due_results.size()));
		if (fault_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/swl_pkg.sv
sv/swl_if.sv
sv/stop_wait_link_sequencer.sv
sv/swl_chk.sv
bench/stop_wait_link_sequencer_test.sv
